/* hdl/cbpe_pkg.sv */
// Shared widths, types and register codes for the cubic Bezier point evaluator.
// No dependencies; imported by every module of the block.
`default_nettype none

package cbpe_pkg;

    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 16;

    localparam int T_W       = PARAM_FRAC_BITS + 1;
    localparam int T3_W      = T_W + 2;
    localparam int SQ_W      = 2 * PARAM_FRAC_BITS + 1;
    localparam int WT_W      = 3 * PARAM_FRAC_BITS + 1;
    localparam int PROD_W    = WT_W + 1 + COORD_BITS;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RND_SHIFT = 3 * PARAM_FRAC_BITS;
    localparam int NUM_PTS   = 4;
    localparam int REG_IDX_W = 3;

    localparam logic [T_W-1:0] ONE_T = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (RND_SHIFT - 1);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } t_reg_idx;

    typedef logic [NUM_PTS-1:0][WT_W-1:0] t_weights;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    typedef t_point [NUM_PTS-1:0] t_ctrl;

endpackage

`default_nettype wire

/* hdl/cbpe_weights.sv */
// Bernstein weight pipeline: clamp t, squares, then the four cubic weights.
// Three register stages with valid/ready flow control; uses cbpe_pkg.
`default_nettype none

module cbpe_weights (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [cbpe_pkg::T_W-1:0]      i_param_t,
    output logic                         o_valid,
    input  wire                          i_ready,
    output cbpe_pkg::t_weights           o_weights
);
    import cbpe_pkg::*;

    logic [2:0]           r_vld;
    logic [2:0]           w_en;

    logic [T_W-1:0]       n_t1, n_u1, r_t1, r_u1;
    logic [2*T_W-1:0]     w_uu_full, w_tt_full;
    logic [SQ_W-1:0]      r_uu2, r_tt2;
    logic [T_W-1:0]       r_t2, r_u2;
    logic [T3_W-1:0]      n_t3, n_u3, r_t3, r_u3;
    logic [SQ_W+T3_W-1:0] w_p0, w_p1, w_p2, w_p3;
    t_weights             r_w;

    always_comb begin
        w_en[2] = !r_vld[2] || i_ready;
        w_en[1] = !r_vld[1] || w_en[2];
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_ready   = w_en[0];
    assign o_valid   = r_vld[2];
    assign o_weights = r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    // clamp t to one, form u = 1 - t
    always_comb begin
        n_t1 = (i_param_t > ONE_T) ? ONE_T : i_param_t;
        n_u1 = ONE_T - n_t1;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r_t1 <= n_t1;
            r_u1 <= n_u1;
        end
    end

    always_comb begin
        w_uu_full = r_u1 * r_u1;
        w_tt_full = r_t1 * r_t1;
        n_t3      = {2'b00, r_t1} + {1'b0, r_t1, 1'b0};
        n_u3      = {2'b00, r_u1} + {1'b0, r_u1, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1] && r_vld[0]) begin
            r_uu2 <= w_uu_full[SQ_W-1:0];
            r_tt2 <= w_tt_full[SQ_W-1:0];
            r_t2  <= r_t1;
            r_u2  <= r_u1;
            r_t3  <= n_t3;
            r_u3  <= n_u3;
        end
    end

    always_comb begin
        w_p0 = r_uu2 * {2'b00, r_u2};
        w_p1 = r_uu2 * r_t3;
        w_p2 = r_tt2 * r_u3;
        w_p3 = r_tt2 * {2'b00, r_t2};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2] && r_vld[1]) begin
            r_w[0] <= w_p0[WT_W-1:0];
            r_w[1] <= w_p1[WT_W-1:0];
            r_w[2] <= w_p2[WT_W-1:0];
            r_w[3] <= w_p3[WT_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* hdl/cbpe_blend.sv */
// Weighted blend of the control points: products, pair sums, final sum and rounding.
// Three register stages with valid/ready flow control; uses cbpe_pkg.
`default_nettype none

module cbpe_blend (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  cbpe_pkg::t_weights                  i_weights,
    input  cbpe_pkg::t_ctrl                     i_ctrl,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic signed [cbpe_pkg::COORD_BITS-1:0] o_point_x,
    output logic signed [cbpe_pkg::COORD_BITS-1:0] o_point_y
);
    import cbpe_pkg::*;

    logic [2:0]                    r_vld;
    logic [2:0]                    w_en;

    logic signed [PROD_W-1:0]      n_px [NUM_PTS];
    logic signed [PROD_W-1:0]      n_py [NUM_PTS];
    logic signed [PROD_W-1:0]      r_px [NUM_PTS];
    logic signed [PROD_W-1:0]      r_py [NUM_PTS];
    logic signed [SUM_W-1:0]       r_sx [2];
    logic signed [SUM_W-1:0]       r_sy [2];
    logic signed [SUM_W-1:0]       n_accx, n_accy;
    logic signed [COORD_BITS-1:0]  r_x, r_y;

    always_comb begin
        w_en[2] = !r_vld[2] || i_ready;
        w_en[1] = !r_vld[1] || w_en[2];
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_ready   = w_en[0];
    assign o_valid   = r_vld[2];
    assign o_point_x = r_x;
    assign o_point_y = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_PTS; k++) begin
            n_px[k] = $signed({1'b0, i_weights[k]}) * $signed(i_ctrl[k].x);
            n_py[k] = $signed({1'b0, i_weights[k]}) * $signed(i_ctrl[k].y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1] && r_vld[0]) begin
            r_sx[0] <= SUM_W'(r_px[0]) + SUM_W'(r_px[1]);
            r_sx[1] <= SUM_W'(r_px[2]) + SUM_W'(r_px[3]);
            r_sy[0] <= SUM_W'(r_py[0]) + SUM_W'(r_py[1]);
            r_sy[1] <= SUM_W'(r_py[2]) + SUM_W'(r_py[3]);
        end
    end

    // round half up, then drop the weight fraction
    always_comb begin
        n_accx = r_sx[0] + r_sx[1] + RND_HALF;
        n_accy = r_sy[0] + r_sy[1] + RND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2] && r_vld[1]) begin
            r_x <= n_accx[RND_SHIFT +: COORD_BITS];
            r_y <= n_accy[RND_SHIFT +: COORD_BITS];
        end
    end

endmodule

`default_nettype wire

/* hdl/cubic_bezier_point_eval.sv */
// Cubic Bezier point evaluator, top level: control point registers and the pipeline.
// Throughput: one request per cycle unless the result side stalls; six register stages, each with its own valid bit.
// Reset: synchronous, active low; clears all pipeline valid bits and sets every
// control point coordinate to zero.
// Depends on cbpe_pkg, cbpe_weights and cbpe_blend.
`default_nettype none

module cubic_bezier_point_eval (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire [cbpe_pkg::REG_IDX_W-1:0]          i_cfg_index,
    input  wire [cbpe_pkg::COORD_BITS-1:0]         i_cfg_data,
    input  wire                                    i_valid,
    output logic                                   o_ready,
    input  wire [cbpe_pkg::T_W-1:0]                i_param_t,
    output logic                                   o_valid,
    input  wire                                    i_ready,
    output logic signed [cbpe_pkg::COORD_BITS-1:0] o_point_x,
    output logic signed [cbpe_pkg::COORD_BITS-1:0] o_point_y
);
    import cbpe_pkg::*;

    t_ctrl    r_ctrl;
    t_weights w_weights;
    logic     w_wt_valid;
    logic     w_wt_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_P0_X: r_ctrl[0].x <= i_cfg_data;
                REG_P0_Y: r_ctrl[0].y <= i_cfg_data;
                REG_P1_X: r_ctrl[1].x <= i_cfg_data;
                REG_P1_Y: r_ctrl[1].y <= i_cfg_data;
                REG_P2_X: r_ctrl[2].x <= i_cfg_data;
                REG_P2_Y: r_ctrl[2].y <= i_cfg_data;
                REG_P3_X: r_ctrl[3].x <= i_cfg_data;
                REG_P3_Y: r_ctrl[3].y <= i_cfg_data;
                default: r_ctrl <= r_ctrl;
            endcase
        end
    end

    cbpe_weights u_weights (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_param_t (i_param_t),
        .o_valid   (w_wt_valid),
        .i_ready   (w_wt_ready),
        .o_weights (w_weights)
    );

    cbpe_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_wt_valid),
        .o_ready   (w_wt_ready),
        .i_weights (w_weights),
        .i_ctrl    (r_ctrl),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y)
    );

endmodule

`default_nettype wire

/* hdl/cbpe_checker.sv */
// Port-level checks for the cubic Bezier point evaluator, bound to the top level.
// Depends on cbpe_pkg and cubic_bezier_point_eval.
`default_nettype none

module cbpe_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_cfg_we,
    input wire [cbpe_pkg::REG_IDX_W-1:0]    i_cfg_index,
    input wire [cbpe_pkg::COORD_BITS-1:0]   i_cfg_data,
    input wire                              i_valid,
    input wire                              o_ready,
    input wire [cbpe_pkg::T_W-1:0]          i_param_t,
    input wire                              o_valid,
    input wire                              i_ready,
    input wire [cbpe_pkg::COORD_BITS-1:0]   o_point_x,
    input wire [cbpe_pkg::COORD_BITS-1:0]   o_point_y
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request stalled with empty output stage");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("request stalled while result side is ready");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_point_x) && $stable(o_point_y))
        else $error("stalled result changed or dropped");

endmodule

bind cubic_bezier_point_eval cbpe_checker u_checker (.*);

`default_nettype wire
